// ===== sv/tgf_pkg.sv =====
// Package for the grouped team FIFO: sizes, codes and payload types.
package tgf_pkg;

  localparam int TEAMS        = 16;
  localparam int MEMBER_SLOTS = 256;
  localparam int QUEUE_DEPTH  = 64;
  localparam int ID_BITS      = 20;

  localparam int ID_W   = (ID_BITS < 20) ? ID_BITS : 20;
  localparam int TM_W   = (TEAMS > 1) ? $clog2(TEAMS) : 1;
  localparam int MT_AW  = (MEMBER_SLOTS > 1) ? $clog2(MEMBER_SLOTS) : 1;
  localparam int MT_CW  = $clog2(MEMBER_SLOTS + 1);
  localparam int Q_AW   = $clog2(QUEUE_DEPTH);
  localparam int Q_CW   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] CMD_BIND  = 2'd0;
  localparam logic [1:0] CMD_ENQ   = 2'd1;
  localparam logic [1:0] CMD_DEQ   = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_EMPTY      = 3'd1;
  localparam logic [2:0] ST_UNKNOWN    = 3'd2;
  localparam logic [2:0] ST_QFULL      = 3'd3;
  localparam logic [2:0] ST_TABLE_FULL = 3'd4;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [19:0] member_id;
    logic [3:0]  team_index;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [19:0] popped_id;
  } out_t;

  // One stored (id, team) pair, used by the member table and the node store.
  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [TM_W-1:0] team;
  } entry_t;

  typedef struct packed {
    logic            clear;
    logic            scan;
    logic            write;
    logic [ID_W-1:0] id;
    logic [TM_W-1:0] team;
  } mt_req_t;

  typedef struct packed {
    logic            done;
    logic            found;
    logic            pair_hit;
    logic            full;
    logic [TM_W-1:0] best_team;
  } mt_stat_t;

endpackage

// ===== sv/tgf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tgf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/tgf_member_table.sv =====
// Member table: bound pairs in a RAM, searched one entry per cycle.
module tgf_member_table import tgf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mt_req_t  req,
  output mt_stat_t stat
);

  logic [MT_CW-1:0] count;
  logic [MT_CW-1:0] idx;
  logic             scanning;
  logic             rd_pend;
  logic             found;
  logic             pair_hit;
  logic [TM_W-1:0]  best;
  logic [ID_W-1:0]  key_id;
  logic [TM_W-1:0]  key_team;
  logic             issue;
  logic             we;
  entry_t           rd_q;

  assign issue = scanning && (idx < count);
  assign we    = req.write && (count < MT_CW'(MEMBER_SLOTS));

  tgf_ram #(.WIDTH($bits(entry_t)), .DEPTH(MEMBER_SLOTS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (count[MT_AW-1:0]),
    .wdata ({key_id, key_team}),
    .raddr (idx[MT_AW-1:0]),
    .rdata (rd_q)
  );

  assign stat.done      = scanning && !rd_pend && !issue;
  assign stat.found     = found;
  assign stat.pair_hit  = pair_hit;
  assign stat.full      = (count >= MT_CW'(MEMBER_SLOTS));
  assign stat.best_team = best;

  always_ff @(posedge clk) begin
    if (rst || req.clear) begin
      count    <= '0;
      scanning <= 1'b0;
      rd_pend  <= 1'b0;
    end else if (req.scan) begin
      idx      <= '0;
      scanning <= 1'b1;
      rd_pend  <= 1'b0;
      found    <= 1'b0;
      pair_hit <= 1'b0;
      key_id   <= req.id;
      key_team <= req.team;
    end else begin
      if (rd_pend && rd_q.id == key_id) begin
        if (!found || rd_q.team < best) begin
          best <= rd_q.team;
        end
        found <= 1'b1;
        if (rd_q.team == key_team) begin
          pair_hit <= 1'b1;
        end
      end
      rd_pend <= issue;
      if (issue) begin
        idx <= idx + 1'b1;
      end
      if (stat.done) begin
        scanning <= 1'b0;
      end
      if (we) begin
        count <= count + 1'b1;
      end
    end
  end

endmodule

// ===== sv/team_grouped_fifo.sv =====
// Top level of the grouped team FIFO: command sequencer and linked node store.
//
//  channel  | ports                  | handshake
//  ---------+------------------------+-------------------------------
//  request  | start, busy, req       | taken when start && !busy
//  result   | done, res              | done high for one cycle
//
// A bind or enqueue searches the member table one entry per cycle; an enqueue
// then goes on through S_E0, S_E1, S_E2 (only when the team already has a last
// node) and S_E3 on the node and link RAMs. A dequeue goes through S_D0, S_D1
// and, unless it empties the queue, S_D2. A clear, a dequeue on an empty queue
// and a bind to a team out of range answer from idle without a search; other
// rejected requests answer when the search ends. Reset and clear need no sweep.
// The result shows in the first cycle with busy low again and cannot be held off.
module team_grouped_fifo import tgf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  in_t  req,
  output logic busy,
  output logic done,
  output out_t res
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SCAN = 4'd1;
  localparam logic [3:0] S_E0   = 4'd2;
  localparam logic [3:0] S_E1   = 4'd3;
  localparam logic [3:0] S_E2   = 4'd4;
  localparam logic [3:0] S_E3   = 4'd5;
  localparam logic [3:0] S_D0   = 4'd6;
  localparam logic [3:0] S_D1   = 4'd7;
  localparam logic [3:0] S_D2   = 4'd8;

  logic [3:0]      st;
  logic            is_bind;
  logic [ID_W-1:0] id_r;
  logic [TM_W-1:0] team_r;
  logic [Q_AW-1:0] alloc_n;
  logic [Q_AW-1:0] q_head;
  logic [Q_AW-1:0] q_tail;
  logic [Q_CW-1:0] q_count;
  logic [Q_AW-1:0] free_head;
  logic [Q_CW-1:0] fresh_cnt;
  logic [Q_AW-1:0] last_node [TEAMS];
  logic [TEAMS-1:0] last_valid;
  logic [ID_W-1:0] pop_id;
  logic [TM_W-1:0] pop_team;
  logic [Q_AW-1:0] prev;
  logic            accept;
  logic [ID_W-1:0] in_id;
  logic            done_next;

  mt_req_t  mt_req;
  mt_stat_t mt_stat;

  logic            nd_we;
  logic [Q_AW-1:0] nd_raddr;
  entry_t          nd_q;
  logic            lk_we;
  logic [Q_AW-1:0] lk_waddr;
  logic [Q_AW-1:0] lk_wdata;
  logic [Q_AW-1:0] lk_raddr;
  logic [Q_AW-1:0] lk_q;

  assign busy   = (st != S_IDLE);
  assign accept = start && !busy;
  assign in_id  = req.member_id[ID_W-1:0];
  assign prev   = last_node[team_r];

  always_comb begin
    mt_req.clear = accept && (req.cmd == CMD_CLEAR);
    mt_req.scan  = accept && ((req.cmd == CMD_ENQ) ||
                   ((req.cmd == CMD_BIND) && (32'(req.team_index) < TEAMS)));
    mt_req.id    = in_id;
    mt_req.team  = TM_W'(req.team_index);
    mt_req.write = (st == S_SCAN) && mt_stat.done && is_bind &&
                   !mt_stat.pair_hit && !mt_stat.full;
  end

  tgf_member_table u_members (
    .clk  (clk),
    .rst  (rst),
    .req  (mt_req),
    .stat (mt_stat)
  );

  tgf_ram #(.WIDTH($bits(entry_t)), .DEPTH(QUEUE_DEPTH)) u_nodes (
    .clk   (clk),
    .we    (nd_we),
    .waddr (alloc_n),
    .wdata ({id_r, team_r}),
    .raddr (nd_raddr),
    .rdata (nd_q)
  );

  tgf_ram #(.WIDTH(Q_AW), .DEPTH(QUEUE_DEPTH)) u_links (
    .clk   (clk),
    .we    (lk_we),
    .waddr (lk_waddr),
    .wdata (lk_wdata),
    .raddr (lk_raddr),
    .rdata (lk_q)
  );

  always_comb begin
    nd_we    = (st == S_E1);
    nd_raddr = (st == S_D1) ? lk_q : q_head;
    lk_we    = 1'b0;
    lk_waddr = q_tail;
    lk_wdata = alloc_n;
    unique case (st)
      S_E1:    lk_raddr = prev;
      S_D0:    lk_raddr = q_head;
      default: lk_raddr = free_head;
    endcase
    unique case (st)
      S_E1: begin
        lk_we = (q_count != '0) && !last_valid[team_r];
      end
      S_E2: begin
        lk_we    = 1'b1;
        lk_waddr = alloc_n;
        lk_wdata = lk_q;
      end
      S_E3: begin
        lk_we    = (q_count != '0) && last_valid[team_r];
        lk_waddr = prev;
      end
      S_D1: begin
        lk_we    = 1'b1;
        lk_waddr = q_head;
        lk_wdata = free_head;
      end
      default: begin
        lk_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    done_next = 1'b0;
    unique case (st)
      S_IDLE: begin
        done_next = accept && ((req.cmd == CMD_CLEAR) ||
                    ((req.cmd == CMD_DEQ) && (q_count == '0)) ||
                    ((req.cmd == CMD_BIND) && !(32'(req.team_index) < TEAMS)));
      end
      S_SCAN: begin
        done_next = mt_stat.done && (is_bind || !mt_stat.found ||
                    (q_count >= Q_CW'(QUEUE_DEPTH)));
      end
      S_E3, S_D2: begin
        done_next = 1'b1;
      end
      S_D1: begin
        done_next = (q_count == Q_CW'(1));
      end
      default: begin
        done_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= S_IDLE;
      q_count    <= '0;
      q_head     <= '0;
      q_tail     <= '0;
      free_head  <= '0;
      fresh_cnt  <= '0;
      last_valid <= '0;
    end else begin
      unique case (st)
        S_IDLE: begin
          if (accept) begin
            is_bind <= (req.cmd == CMD_BIND);
            id_r    <= in_id;
            unique case (req.cmd)
              CMD_BIND: begin
                if (32'(req.team_index) < TEAMS) begin
                  st <= S_SCAN;
                end else begin
                  res <= '{status: ST_UNKNOWN, popped_id: '0};
                end
              end
              CMD_ENQ: begin
                st <= S_SCAN;
              end
              CMD_DEQ: begin
                if (q_count == '0) begin
                  res <= '{status: ST_EMPTY, popped_id: '0};
                end else begin
                  st <= S_D0;
                end
              end
              default: begin
                q_count    <= '0;
                q_head     <= '0;
                q_tail     <= '0;
                free_head  <= '0;
                fresh_cnt  <= '0;
                last_valid <= '0;
                res        <= '{status: ST_OK, popped_id: '0};
              end
            endcase
          end
        end
        S_SCAN: begin
          if (mt_stat.done) begin
            if (is_bind) begin
              res  <= '{status: (!mt_stat.pair_hit && mt_stat.full) ? ST_TABLE_FULL : ST_OK,
                        popped_id: '0};
              st   <= S_IDLE;
            end else if (!mt_stat.found) begin
              res  <= '{status: ST_UNKNOWN, popped_id: '0};
              st   <= S_IDLE;
            end else if (q_count >= Q_CW'(QUEUE_DEPTH)) begin
              res  <= '{status: ST_QFULL, popped_id: '0};
              st   <= S_IDLE;
            end else begin
              team_r  <= mt_stat.best_team;
              alloc_n <= free_head;
              st      <= S_E0;
            end
          end
        end
        S_E0: begin
          st <= S_E1;
        end
        S_E1: begin
          // Slots never handed out yet chain to the next slot by count, not by a stored link.
          if ((fresh_cnt < Q_CW'(QUEUE_DEPTH)) && (Q_AW'(fresh_cnt) == alloc_n)) begin
            fresh_cnt <= fresh_cnt + 1'b1;
            free_head <= (32'(alloc_n) == QUEUE_DEPTH - 1) ? '0 : alloc_n + 1'b1;
          end else begin
            free_head <= lk_q;
          end
          if (q_count == '0) begin
            q_head <= alloc_n;
            q_tail <= alloc_n;
            st     <= S_E3;
          end else if (last_valid[team_r]) begin
            st <= S_E2;
          end else begin
            q_tail <= alloc_n;
            st     <= S_E3;
          end
        end
        S_E2: begin
          st <= S_E3;
        end
        S_E3: begin
          // The link write here only matters when the team already had a mark.
          if (last_valid[team_r] && q_count != '0 && prev == q_tail) begin
            q_tail <= alloc_n;
          end
          last_node[team_r]  <= alloc_n;
          last_valid[team_r] <= 1'b1;
          q_count            <= q_count + 1'b1;
          res                <= '{status: ST_OK, popped_id: '0};
          st                 <= S_IDLE;
        end
        S_D0: begin
          st <= S_D1;
        end
        S_D1: begin
          pop_id    <= nd_q.id;
          pop_team  <= nd_q.team;
          q_head    <= lk_q;
          free_head <= q_head;
          q_count   <= q_count - 1'b1;
          if (q_count == Q_CW'(1)) begin
            last_valid[nd_q.team] <= 1'b0;
            res <= '{status: ST_OK, popped_id: 20'(nd_q.id)};
            st  <= S_IDLE;
          end else begin
            st <= S_D2;
          end
        end
        S_D2: begin
          if (nd_q.team != pop_team) begin
            last_valid[pop_team] <= 1'b0;
          end
          res <= '{status: ST_OK, popped_id: 20'(pop_id)};
          st  <= S_IDLE;
        end
        default: begin
          st <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== tb/tb_team_grouped_fifo.sv =====
// Self-checking testbench for the grouped team FIFO: driven requests, predicted results.
`timescale 1ns / 100ps

class team_queue_scoreboard;
  logic [19:0] bound_ids[$];
  logic [3:0] bound_teams[$];
  logic [19:0] node_id[tgf_pkg::QUEUE_DEPTH];
  logic [3:0] node_team[tgf_pkg::QUEUE_DEPTH];
  int node_next[tgf_pkg::QUEUE_DEPTH];
  int last_node[tgf_pkg::TEAMS];
  bit last_ok[tgf_pkg::TEAMS];
  int head, tail, count, free_head;
  tgf_pkg::out_t pending[$];
  int mismatches;

  function new();
    mismatches = 0;
    wipe();
  endfunction

  function void wipe();
    bound_ids.delete();
    bound_teams.delete();
    for (int i = 0; i < tgf_pkg::QUEUE_DEPTH; i++) begin
      node_next[i] = (i + 1) % tgf_pkg::QUEUE_DEPTH;
    end
    foreach (last_ok[t]) begin
      last_ok[t] = 0;
    end
    head = 0;
    tail = 0;
    count = 0;
    free_head = 0;
  endfunction

  // Notes one accepted request and queues the result it must produce.
  function void note_request(tgf_pkg::in_t r);
    tgf_pkg::out_t o;
    bit found, hit;
    logic [3:0] best;
    int n, prev, h;
    o = '0;
    found = 0;
    hit = 0;
    best = 0;
    foreach (bound_ids[i]) begin
      if (bound_ids[i] == r.member_id) begin
        if (!found || bound_teams[i] < best) best = bound_teams[i];
        found = 1;
        if (bound_teams[i] == r.team_index) hit = 1;
      end
    end
    case (r.cmd)
      tgf_pkg::CMD_BIND: begin
        if (!hit) begin
          if (bound_ids.size() >= tgf_pkg::MEMBER_SLOTS) begin
            o.status = tgf_pkg::ST_TABLE_FULL;
          end else begin
            bound_ids.push_back(r.member_id);
            bound_teams.push_back(r.team_index);
          end
        end
      end
      tgf_pkg::CMD_ENQ: begin
        if (!found) begin
          o.status = tgf_pkg::ST_UNKNOWN;
        end else if (count >= tgf_pkg::QUEUE_DEPTH) begin
          o.status = tgf_pkg::ST_QFULL;
        end else begin
          n = free_head;
          free_head = node_next[n];
          node_id[n] = r.member_id;
          node_team[n] = best;
          if (count == 0) begin
            head = n;
            tail = n;
          end else if (last_ok[best]) begin
            prev = last_node[best];
            node_next[n] = node_next[prev];
            node_next[prev] = n;
            if (prev == tail) tail = n;
          end else begin
            node_next[tail] = n;
            tail = n;
          end
          last_node[best] = n;
          last_ok[best] = 1;
          count++;
        end
      end
      tgf_pkg::CMD_DEQ: begin
        if (count == 0) begin
          o.status = tgf_pkg::ST_EMPTY;
        end else begin
          h = head;
          o.popped_id = node_id[h];
          if (count == 1 || node_team[node_next[h]] != node_team[h]) begin
            last_ok[node_team[h]] = 0;
          end
          head = node_next[h];
          node_next[h] = free_head;
          free_head = h;
          count--;
        end
      end
      default: wipe();
    endcase
    pending.push_back(o);
  endfunction

  function void check_result(tgf_pkg::out_t got);
    tgf_pkg::out_t exp_res;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h", got);
      return;
    end
    exp_res = pending.pop_front();
    if (got.status !== exp_res.status || got.popped_id !== exp_res.popped_id) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch: expected status %0d id %h, got status %0d id %h",
                 exp_res.status, exp_res.popped_id, got.status, got.popped_id);
      end
    end
  endfunction
endclass

module tb_team_grouped_fifo;
  import tgf_pkg::*;

  logic clk;
  logic rst;
  logic start;
  in_t req;
  logic busy;
  logic done;
  out_t res;

  team_queue_scoreboard board;
  logic [19:0] id_pool[16];

  team_grouped_fifo dut (
    .clk(clk), .rst(rst), .start(start), .req(req),
    .busy(busy), .done(done), .res(res)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #30ms;
    $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && done) board.check_result(res);
  end

  // Presents one request after a random gap and holds it until taken.
  // With no gap, start simply stays high into the next request.
  task automatic send(logic [1:0] c, logic [19:0] id, logic [3:0] t);
    int gap;
    gap = $urandom_range(0, 6);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req <= '{cmd: c, member_id: id, team_index: t};
    do @(posedge clk); while (busy);
    board.note_request(req);
  endtask

  initial begin
    int cnt, k, pick;
    board = new();
    rst <= 1'b1;
    start <= 1'b0;
    req <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty dequeue, unknown member, extremes, grouping, clear.
    send(CMD_DEQ, 20'hFFFFF, 4'hF);
    send(CMD_ENQ, 20'h00000, 4'h0);
    send(CMD_BIND, 20'h00000, 4'h0);
    send(CMD_BIND, 20'hFFFFF, 4'hF);
    send(CMD_BIND, 20'hFFFFF, 4'h3);
    send(CMD_BIND, 20'hFFFFF, 4'h3);
    send(CMD_BIND, 20'h12345, 4'h7);
    send(CMD_ENQ, 20'hFFFFF, 4'h0);
    send(CMD_ENQ, 20'h12345, 4'h0);
    send(CMD_ENQ, 20'h00000, 4'h0);
    send(CMD_ENQ, 20'hFFFFF, 4'h0);
    send(CMD_ENQ, 20'h12345, 4'h0);
    for (int i = 0; i < 6; i++) send(CMD_DEQ, 20'h0, 4'h0);
    send(CMD_CLEAR, 20'hABCDE, 4'h5);
    send(CMD_ENQ, 20'hFFFFF, 4'h0);
    // Fill the table to overflow.
    for (int i = 0; i <= MEMBER_SLOTS; i++) send(CMD_BIND, 20'(i * 4099), 4'(i));
    send(CMD_BIND, 20'hFFFFF, 4'hE);
    send(CMD_CLEAR, 20'h0, 4'h0);

    // Random phases, each over a fresh small pool of ids.
    cnt = 0;
    while (cnt < 1330) begin
      foreach (id_pool[i]) id_pool[i] = 20'($urandom);
      for (int i = 0; i < 16; i++) begin
        send(CMD_BIND, id_pool[i], 4'($urandom_range(0, 5)));
        cnt++;
      end
      // Bias toward enqueues to reach a full queue in some phases.
      pick = $urandom_range(0, 1);
      k = $urandom_range(60, 160);
      repeat (k) begin
        case ($urandom_range(0, 19))
          0: send(CMD_BIND, id_pool[$urandom_range(0, 15)], 4'($urandom));
          1: send(CMD_ENQ, 20'($urandom), 4'($urandom));
          2, 3, 4, 5, 6, 7: send(CMD_DEQ, 20'($urandom), 4'($urandom));
          8, 9: send(pick ? CMD_ENQ : CMD_DEQ, id_pool[$urandom_range(0, 15)],
                     4'($urandom));
          default: send(CMD_ENQ, id_pool[$urandom_range(0, 15)], 4'($urandom));
        endcase
        cnt++;
      end
      send(CMD_CLEAR, 20'($urandom), 4'($urandom));
      cnt++;
    end
    start <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
